[sv/terminal_line_editor_macros.svh]
// assertion macros for the terminal line editor
// used by modules that check their own logic; expects clk and rst_n in scope
`ifndef TERMINAL_LINE_EDITOR_MACROS_SVH
`define TERMINAL_LINE_EDITOR_MACROS_SVH

// expression must hold at every edge out of reset
`define TLE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/tle_pkg.sv]
// shared types and constants of the terminal line editor
// no dependencies; imported by every module of the block but tle_ram
package tle_pkg;

  // default buffer size, line holds one less character
  localparam int BUFFER_SIZE_DEF = 32;

  // width of the length and cursor result fields
  localparam int POS_OUT_W = 5;

  // terminal byte codes
  localparam logic [7:0] CHAR_BS       = 8'h08;
  localparam logic [7:0] CHAR_CR       = 8'h0d;
  localparam logic [7:0] CHAR_ESC      = 8'h1b;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_DEL      = 8'h7f;
  localparam logic [7:0] CHAR_LBRACKET = 8'h5b;
  localparam logic [7:0] CHAR_LEFT     = 8'h44;
  localparam logic [7:0] CHAR_RIGHT    = 8'h43;
  localparam logic [7:0] CHAR_DELETE   = 8'h33;
  localparam logic [7:0] CHAR_HOME     = 8'h31;
  localparam logic [7:0] CHAR_END      = 8'h34;

  // escape parser phase
  typedef enum logic [1:0] {
    ESC_IDLE   = 2'd0,
    ESC_SEEN   = 2'd1,
    ESC_CSI    = 2'd2,
    ESC_ABSORB = 2'd3
  } esc_t;

  // result item kind
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SHIFT,
    S_INS_DRAIN,
    S_INS_PUT,
    S_DEL_SHIFT,
    S_DEL_DRAIN,
    S_DEL_FIN,
    S_STATUS,
    S_EMPTY,
    S_LINE_RD,
    S_LINE_OUT
  } ctl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;      // latch the input byte
    logic decode;      // apply escape and cursor moves, set shift index
    logic mv_read;     // read one character of a shift
    logic mv_up;       // shift direction: toward lower addresses
    logic ins_put;     // write inserted byte at the cursor
    logic rm_fin;      // finish a removal
    logic line_rd;     // read one character of the completed line
    logic out_status;  // load a status item
    logic out_char;    // load a line character item
    logic out_empty;   // load an empty line item
    logic clear;       // clear line, cursor and parser
  } tle_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_cr;
    logic len_zero;
    logic do_insert;
    logic do_bs;
    logic do_del;
    logic ins_shift;   // characters sit at or after the cursor
    logic rm_shift;    // characters sit after the removed one
    logic idx_at_cur;
    logic idx_at_end;
    logic out_free;
  } tle_stat_t;

endpackage

[sv/tle_ram.sv]
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module tle_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 31,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/tle_ctrl.sv]
// controller state machine of the terminal line editor
// depends on tle_pkg for states, commands and status
module tle_ctrl import tle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tle_stat_t st,
  output tle_cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        priority if (st.is_cr) begin
          state_nxt = st.len_zero ? S_EMPTY : S_LINE_RD;
        end else if (st.do_insert) begin
          state_nxt = st.ins_shift ? S_INS_SHIFT : S_INS_PUT;
        end else if (st.do_bs || st.do_del) begin
          state_nxt = st.rm_shift ? S_DEL_SHIFT : S_DEL_FIN;
        end else begin
          state_nxt = S_STATUS;
        end
      end
      // move characters up one place, from the end down to the cursor
      S_INS_SHIFT: begin
        cmd.mv_read = 1'b1;
        if (st.idx_at_cur) begin
          state_nxt = S_INS_DRAIN;
        end
      end
      S_INS_DRAIN: begin
        state_nxt = S_INS_PUT;
      end
      S_INS_PUT: begin
        cmd.ins_put = 1'b1;
        state_nxt   = S_STATUS;
      end
      // move characters down one place, up to the end
      S_DEL_SHIFT: begin
        cmd.mv_read = 1'b1;
        cmd.mv_up   = 1'b1;
        if (st.idx_at_end) begin
          state_nxt = S_DEL_DRAIN;
        end
      end
      S_DEL_DRAIN: begin
        state_nxt = S_DEL_FIN;
      end
      S_DEL_FIN: begin
        cmd.rm_fin = 1'b1;
        state_nxt  = S_STATUS;
      end
      S_STATUS: begin
        if (st.out_free) begin
          cmd.out_status = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (st.out_free) begin
          cmd.out_empty = 1'b1;
          cmd.clear     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      // completed line, one character per read and output pair
      S_LINE_RD: begin
        cmd.line_rd = 1'b1;
        state_nxt   = S_LINE_OUT;
      end
      S_LINE_OUT: begin
        if (st.out_free) begin
          cmd.out_char = 1'b1;
          if (st.idx_at_end) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LINE_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[sv/tle_datapath.sv]
// datapath of the terminal line editor: decode, line ram, length and cursor,
// output register; depends on tle_pkg, tle_ram and the assertion macros
`include "terminal_line_editor_macros.svh"

module tle_datapath import tle_pkg::*; #(
  parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_byte,
  input  tle_cmd_t             cmd,
  output tle_stat_t            st,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_kind,
  output logic [6:0]           out_data_char,
  output logic                 out_last,
  output logic [POS_OUT_W-1:0] out_line_length,
  output logic [POS_OUT_W-1:0] out_cursor_pos
);

  localparam int LINE_CAP = BUFFER_SIZE - 1;
  localparam int LEN_W    = $clog2(BUFFER_SIZE);
  localparam int ADDR_W   = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;

  logic [7:0]           byte_r, byte_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [LEN_W-1:0]     cur_r, cur_nxt;
  logic [LEN_W-1:0]     idx_r, idx_nxt;
  esc_t                 esc_r, esc_nxt;
  logic                 rm_bs_r, rm_bs_nxt;
  logic                 mv_pend_r, mv_pend_nxt;
  logic [ADDR_W-1:0]    mv_dst_r, mv_dst_nxt;
  logic                 out_valid_r, out_valid_nxt;
  kind_t                out_kind_r, out_kind_nxt;
  logic [6:0]           out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [POS_OUT_W-1:0] out_len_r, out_len_nxt;
  logic [POS_OUT_W-1:0] out_cur_r, out_cur_nxt;

  logic                 is_print;
  logic                 cur_lt_len;
  logic                 cur1_lt_len;
  logic                 len_full;
  logic [LEN_W:0]       cur_inc;
  logic [LEN_W:0]       idx_inc;
  logic [LEN_W-1:0]     idx_up;
  logic [LEN_W-1:0]     idx_dn;
  logic [LEN_W-1:0]     idx_init;
  esc_t                 esc_dec;
  logic [LEN_W-1:0]     cur_dec;
  logic                 out_load;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [6:0]           ram_wdata;
  logic                 ram_re;
  logic [6:0]           ram_rdata;

  // byte classification and position compares
  assign is_print    = (byte_r >= CHAR_SPACE) && (byte_r < CHAR_DEL);
  assign cur_lt_len  = (cur_r < len_r);
  assign cur_inc     = {1'b0, cur_r} + 1'b1;
  assign cur1_lt_len = (cur_inc < {1'b0, len_r});
  assign len_full    = (len_r >= LEN_W'(LINE_CAP));
  assign idx_inc     = {1'b0, idx_r} + 1'b1;
  assign idx_up      = idx_inc[LEN_W-1:0];
  assign idx_dn      = idx_r - 1'b1;

  // status toward the controller
  always_comb begin
    st.is_cr      = (byte_r == CHAR_CR);
    st.len_zero   = (len_r == '0);
    st.do_insert  = !st.is_cr && (esc_r == ESC_IDLE) && is_print && !len_full;
    st.do_del     = !st.is_cr && (esc_r == ESC_CSI) && (byte_r == CHAR_DELETE) && cur_lt_len;
    st.do_bs      = (byte_r == CHAR_BS) && (cur_r != '0) && (len_r != '0);
    st.ins_shift  = cur_lt_len;
    st.rm_shift   = st.do_bs ? cur_lt_len : cur1_lt_len;
    st.idx_at_cur = (idx_r == cur_r);
    st.idx_at_end = (idx_inc == {1'b0, len_r});
    st.out_free   = !out_valid_r || !out_stall;
  end

  // escape parser step
  always_comb begin
    unique case (esc_r)
      ESC_IDLE:   esc_dec = (byte_r == CHAR_ESC) ? ESC_SEEN : ESC_IDLE;
      ESC_SEEN:   esc_dec = (byte_r == CHAR_LBRACKET) ? ESC_CSI : ESC_SEEN;
      ESC_CSI: begin
        if ((byte_r == CHAR_DELETE) || (byte_r == CHAR_HOME) || (byte_r == CHAR_END)) begin
          esc_dec = ESC_ABSORB;
        end else begin
          esc_dec = ESC_IDLE;
        end
      end
      ESC_ABSORB: esc_dec = ESC_IDLE;
      default:    esc_dec = ESC_IDLE;
    endcase
  end

  // cursor moves of the escape final byte
  always_comb begin
    cur_dec = cur_r;
    if (esc_r == ESC_CSI) begin
      unique case (byte_r)
        CHAR_LEFT: begin
          if (cur_r != '0) begin
            cur_dec = cur_r - 1'b1;
          end
        end
        CHAR_RIGHT: begin
          if (cur_lt_len) begin
            cur_dec = cur_inc[LEN_W-1:0];
          end
        end
        CHAR_HOME: cur_dec = '0;
        CHAR_END:  cur_dec = len_r;
        default:   cur_dec = cur_r;
      endcase
    end
  end

  // first read index of a shift or of the line run
  always_comb begin
    priority if (st.is_cr) begin
      idx_init = '0;
    end else if (st.do_insert) begin
      idx_init = len_r - 1'b1;
    end else if (st.do_del) begin
      idx_init = cur_inc[LEN_W-1:0];
    end else begin
      idx_init = cur_r;
    end
  end

  // line ram ports
  assign ram_re    = cmd.mv_read || cmd.line_rd;
  assign ram_we    = cmd.ins_put || mv_pend_r;
  assign ram_waddr = cmd.ins_put ? cur_r[ADDR_W-1:0] : mv_dst_r;
  assign ram_wdata = cmd.ins_put ? byte_r[6:0] : ram_rdata;

  tle_ram #(
    .WIDTH (7),
    .DEPTH (LINE_CAP)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign out_load = cmd.out_status || cmd.out_char || cmd.out_empty;

  // next values
  always_comb begin
    byte_nxt      = cmd.accept ? in_byte : byte_r;
    len_nxt       = len_r;
    cur_nxt       = cur_r;
    esc_nxt       = esc_r;
    idx_nxt       = idx_r;
    rm_bs_nxt     = cmd.decode ? st.do_bs : rm_bs_r;
    mv_pend_nxt   = cmd.mv_read;
    mv_dst_nxt    = cmd.mv_up ? idx_dn[ADDR_W-1:0] : idx_up[ADDR_W-1:0];
    out_valid_nxt = out_load || (out_valid_r && out_stall);
    out_kind_nxt  = out_kind_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_len_nxt   = out_len_r;
    out_cur_nxt   = out_cur_r;

    // length, cursor and parser
    priority if (cmd.clear) begin
      len_nxt = '0;
      cur_nxt = '0;
      esc_nxt = ESC_IDLE;
    end else if (cmd.decode && !st.is_cr) begin
      cur_nxt = cur_dec;
      esc_nxt = esc_dec;
    end else if (cmd.ins_put) begin
      len_nxt = len_r + 1'b1;
      cur_nxt = cur_inc[LEN_W-1:0];
    end else if (cmd.rm_fin) begin
      len_nxt = len_r - 1'b1;
      if (rm_bs_r) begin
        cur_nxt = cur_r - 1'b1;
      end
    end

    // read index
    priority if (cmd.decode) begin
      idx_nxt = idx_init;
    end else if (cmd.mv_read) begin
      idx_nxt = cmd.mv_up ? idx_up : idx_dn;
    end else if (cmd.out_char) begin
      idx_nxt = idx_up;
    end

    // output item
    if (out_load) begin
      out_char_nxt = cmd.out_char ? ram_rdata : 7'd0;
      out_last_nxt = cmd.out_char ? st.idx_at_end : 1'b1;
      out_len_nxt  = cmd.out_status ? POS_OUT_W'(len_r) : '0;
      out_cur_nxt  = cmd.out_status ? POS_OUT_W'(cur_r) : '0;
      priority if (cmd.out_char) begin
        out_kind_nxt = KIND_CHAR;
      end else if (cmd.out_empty) begin
        out_kind_nxt = KIND_EMPTY;
      end else begin
        out_kind_nxt = KIND_STATUS;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      cur_r       <= '0;
      esc_r       <= ESC_IDLE;
      mv_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      cur_r       <= cur_nxt;
      esc_r       <= esc_nxt;
      mv_pend_r   <= mv_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    idx_r      <= idx_nxt;
    rm_bs_r    <= rm_bs_nxt;
    mv_dst_r   <= mv_dst_nxt;
    out_kind_r <= out_kind_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_len_r  <= out_len_nxt;
    out_cur_r  <= out_cur_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_data_char   = out_char_r;
  assign out_last        = out_last_r;
  assign out_line_length = out_len_r;
  assign out_cursor_pos  = out_cur_r;

  // checks
  `TLE_ASSERT_ALWAYS(a_cur_in_line, cur_r <= len_r, "cursor beyond line length")
  `TLE_ASSERT_ALWAYS(a_len_cap, len_r <= LEN_W'(LINE_CAP), "line length beyond capacity")
  `TLE_ASSERT_ALWAYS(a_one_writer, !(cmd.ins_put && mv_pend_r), "two ram writes in one cycle")
  `TLE_ASSERT_ALWAYS(a_no_overwrite, !(out_load && out_valid_r && out_stall), "result item overwritten")
  `TLE_ASSERT_NEXT(a_shift_write, cmd.mv_read, mv_pend_r, "shift read without write back")

endmodule

[sv/terminal_line_editor.sv]
// Terminal line editor. Bytes enter one at a time on the in_ channel and
// edit one line of up to BUFFER_SIZE-1 characters held in a small RAM.
// Every byte but carriage return gives one status item; carriage return
// gives one item per line character (or one empty-line item) and clears
// the line. One item is worked on at a time. Each byte is accepted and
// then decoded; a byte that only moves the cursor or changes the escape
// state goes straight on to its status item. An insert writes the byte at
// the cursor, and a backspace or delete shortens the line. Where characters
// sit behind the edit point, they first move one place per cycle through
// the RAM's single write port, and a drain state lets the last write end.
// A completed line is read and sent one character at a time. Output
// stalls can delay all of these. The next byte is accepted as soon as the
// last result item sits in the output register, even while it is stalled.
// No clearing pass follows reset.
module terminal_line_editor import tle_pkg::*; #(
  parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_kind,
  output logic [6:0]           out_data_char,
  output logic                 out_last,
  output logic [POS_OUT_W-1:0] out_line_length,
  output logic [POS_OUT_W-1:0] out_cursor_pos
);

  tle_cmd_t  cmd;
  tle_stat_t st;

  // sequencer
  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // line storage and result register
  tle_datapath #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_byte         (in_byte),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data_char   (out_data_char),
    .out_last        (out_last),
    .out_line_length (out_line_length),
    .out_cursor_pos  (out_cursor_pos)
  );

endmodule
